// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/crcfr_pkg.sv =====
// Shared constants, types and the CRC-32 byte update for the frame receiver.
package crcfr_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'h5A;
  localparam logic [7:0] END_MARKER_RST   = 8'hB2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Byte positions within a nine-byte frame
  localparam logic [3:0] POS_START = 4'd0;
  localparam logic [3:0] POS_CMD   = 4'd1;
  localparam logic [3:0] POS_LEN   = 4'd2;
  localparam logic [3:0] POS_DATA  = 4'd3;
  localparam logic [3:0] POS_END   = 4'd4;
  localparam logic [3:0] POS_CRC0  = 4'd5;
  localparam logic [3:0] POS_CRC1  = 4'd6;
  localparam logic [3:0] POS_CRC2  = 4'd7;
  localparam logic [3:0] POS_CRC3  = 4'd8;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } markers_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfr_regs.sv =====
// APB register block holding the start and end marker bytes.
module crcfr_regs import crcfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output markers_t              markers
);

  markers_t markers_r;
  markers_t markers_nxt;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Byte lanes and low address bits are not decoded
  always_comb begin
    markers_nxt = markers_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_START_MARKER: markers_nxt.start_marker = pwdata[7:0];
        REG_END_MARKER:   markers_nxt.end_marker   = pwdata[7:0];
        default:          markers_nxt = markers_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START_MARKER: prdata = {24'd0, markers_r.start_marker};
      REG_END_MARKER:   prdata = {24'd0, markers_r.end_marker};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r.start_marker <= START_MARKER_RST;
      markers_r.end_marker   <= END_MARKER_RST;
    end else begin
      markers_r <= markers_nxt;
    end
  end

  assign markers = markers_r;

endmodule

// ===== hdl/crc32_frame_receiver.sv =====
// Frame receiver: 9-byte frames, result registered on the ninth byte.
// Throughput: one byte per cycle bar a stalled ninth byte; the CRC update is unrolled logic.
// Latency: the result is valid the cycle after the ninth byte's transaction.
// Bytes 1..8 of a frame are taken while a result waits; the ninth waits for the output slot.
// Reset (synchronous, rst_n low): frame position 0, CRC all ones, no result pending,
// markers back to 0x5A and 0xB2.
`include "assert_macros.svh"

module crc32_frame_receiver import crcfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_command_byte,
  output logic [7:0]            out_length_byte,
  output logic [7:0]            out_data_byte,
  output logic                  out_crc_ok,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  markers_t markers;

  logic [3:0]  pos_r,   pos_nxt;
  logic [31:0] crc_r,   crc_nxt;
  logic [7:0]  cmd_r,   cmd_nxt;
  logic [7:0]  len_r,   len_nxt;
  logic [7:0]  data_r,  data_nxt;
  logic [23:0] rxcrc_r, rxcrc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_cmd_r,   out_cmd_nxt;
  logic [7:0]  out_len_r,   out_len_nxt;
  logic [7:0]  out_data_r,  out_data_nxt;
  logic        out_ok_r,    out_ok_nxt;

  logic        last_byte;
  logic        in_fire;
  logic        out_fire;

  crcfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .markers (markers)
  );

  assign last_byte = (pos_r == POS_CRC3);
  // only the closing byte needs the output slot
  assign in_ready  = !last_byte || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    data_nxt      = data_r;
    rxcrc_nxt     = rxcrc_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_cmd_nxt   = out_cmd_r;
    out_len_nxt   = out_len_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    if (in_fire) begin
      pos_nxt = pos_r + 4'd1;
      case (pos_r)
        POS_CMD: begin
          cmd_nxt = in_rx_byte;
          crc_nxt = crc_feed(crc_r, in_rx_byte);
        end
        POS_LEN: begin
          len_nxt = in_rx_byte;
          crc_nxt = crc_feed(crc_r, in_rx_byte);
        end
        POS_DATA: begin
          data_nxt = in_rx_byte;
          crc_nxt  = crc_feed(crc_r, in_rx_byte);
        end
        POS_END:  crc_nxt = crc_feed(crc_r, markers.end_marker);
        POS_CRC0: rxcrc_nxt = {16'd0, in_rx_byte};
        POS_CRC1: rxcrc_nxt[15:8] = in_rx_byte;
        POS_CRC2: rxcrc_nxt[23:16] = in_rx_byte;
        POS_CRC3: begin
          pos_nxt       = POS_START;
          crc_nxt       = CRC_INIT;
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = cmd_r;
          out_len_nxt   = len_r;
          out_data_nxt  = data_r;
          out_ok_nxt    = ({in_rx_byte, rxcrc_r} == ~crc_r);
        end
        // start byte, and any unused position, opens a new frame
        default: begin
          pos_nxt = POS_CMD;
          crc_nxt = crc_feed(CRC_INIT, markers.start_marker);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_START;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    len_r      <= len_nxt;
    data_r     <= data_nxt;
    rxcrc_r    <= rxcrc_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_len_r  <= out_len_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command_byte = out_cmd_r;
  assign out_length_byte  = out_len_r;
  assign out_data_byte    = out_data_r;
  assign out_crc_ok       = out_ok_r;

  `ASSERT_NOW(a_pos_in_frame, clk, rst_n, 1'b1, pos_r <= POS_CRC3)
  `ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !(in_fire && last_byte))
  `ASSERT_NXT(a_frame_close, clk, rst_n, in_fire && last_byte,
              out_valid_r && pos_r == POS_START && crc_r == CRC_INIT)
  `ASSERT_NXT(a_no_spurious, clk, rst_n, !(in_fire && last_byte) && !out_valid_r, !out_valid_r)

endmodule

// ===== sim/crc32_frame_receiver_test.sv =====
// Self-checking testbench for crc32_frame_receiver: byte stream in, frame results out.
module crc32_frame_receiver_test import crcfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_SEED      = 32'hFFFF_FFFF;
  localparam int FRAME_BYTES   = 9;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_ADDR_W-1:0] ADDR_START_MARKER = {REG_START_MARKER, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_END_MARKER   = {REG_END_MARKER, 2'b00};

  typedef enum logic [1:0] {CRC_GOOD, CRC_FLIP, CRC_RAW} crc_kind_t;
  typedef enum logic [1:0] {PACE_OPEN, PACE_COIN, PACE_PERIODIC, PACE_MOSTLY} rx_pace_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] data;
    logic       crc_ok;
  } frame_result_t;

  // crc_arg is the flip mask for CRC_FLIP and the wire value for CRC_RAW
  typedef struct packed {
    logic [7:0]    start_byte;
    logic [7:0]    command;
    logic [7:0]    length;
    logic [7:0]    data;
    logic [7:0]    end_byte;
    crc_kind_t     kind;
    logic [31:0]   crc_arg;
    logic          typed;
    frame_result_t want;
  } frame_plan_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_command_byte;
  logic [7:0]  out_length_byte;
  logic [7:0]  out_data_byte;
  logic        out_crc_ok;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  crc32_frame_receiver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_byte (out_command_byte),
    .out_length_byte  (out_length_byte),
    .out_data_byte    (out_data_byte),
    .out_crc_ok       (out_crc_ok),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // marker settings as the block should hold them
  logic [7:0] mk_start = START_MARKER_RST;
  logic [7:0] mk_end   = END_MARKER_RST;

  // frame receive predictor state
  logic [3:0]  rx_pos     = POS_START;
  logic [31:0] rx_crc     = CRC32_SEED;
  logic [7:0]  rx_command = '0;
  logic [7:0]  rx_length  = '0;
  logic [7:0]  rx_data    = '0;
  logic [23:0] rx_crc_low = '0;

  frame_result_t pending_results[$];
  frame_plan_t   frames_in_flight[$];
  frame_plan_t   queued_plans[$];
  int            errors = 0;

  // sender state
  frame_plan_t cur_plan;
  int          tx_pos = 0;
  logic [7:0]  plan_mk_start;
  logic [7:0]  plan_mk_end;
  logic [31:0] plan_crc_wire;
  int          burst_left = 1;
  bit          gapless = 1'b0;

  // long receiver hold-off requests: main bumps req, receiver catches up
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;

  frame_plan_t directed_frames[3] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CRC_GOOD, 32'h0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CRC_FLIP, 32'h8000_0000, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    // marker values arriving as data, all-ones CRC on the wire
    '{8'h5A, 8'h01, 8'h80, 8'h7F, 8'hB2, CRC_RAW, 32'hFFFF_FFFF, 1'b0,
      '{8'h00, 8'h00, 8'h00, 1'b0}}
  };

  function automatic logic [31:0] crc32_clock_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = {1'b0, r[31:1]} ^ CRC32_POLY_REFL;
      else r = {1'b0, r[31:1]};
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic frame_plan_t random_frame(input logic [7:0] s_mk, input logic [7:0] e_mk);
    frame_plan_t p;
    int r;
    r = $urandom_range(0, 99);
    p.kind       = (r < 75) ? CRC_GOOD : (r < 90) ? CRC_FLIP : CRC_RAW;
    p.crc_arg    = (p.kind == CRC_FLIP) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
    p.start_byte = ($urandom_range(0, 3) == 0) ? s_mk : pick_byte();
    p.end_byte   = ($urandom_range(0, 3) == 0) ? e_mk : pick_byte();
    p.command    = pick_byte();
    p.length     = pick_byte();
    p.data       = pick_byte();
    p.typed      = 1'b0;
    p.want       = '0;
    return p;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // predictor: one accepted byte; markers are sampled at the position they stand in for
  task automatic frame_rx_step(input logic [7:0] b, output bit got, output frame_result_t res);
    got = 1'b0;
    res = '0;
    if (rx_pos > POS_CRC3) rx_pos = POS_START;
    case (rx_pos)
      POS_START: rx_crc = crc32_clock_byte(CRC32_SEED, mk_start);
      POS_CMD: begin
        rx_command = b;
        rx_crc = crc32_clock_byte(rx_crc, b);
      end
      POS_LEN: begin
        rx_length = b;
        rx_crc = crc32_clock_byte(rx_crc, b);
      end
      POS_DATA: begin
        rx_data = b;
        rx_crc = crc32_clock_byte(rx_crc, b);
      end
      POS_END:  rx_crc = crc32_clock_byte(rx_crc, mk_end);
      POS_CRC0: rx_crc_low = {16'h0, b};
      POS_CRC1: rx_crc_low[15:8] = b;
      POS_CRC2: rx_crc_low[23:16] = b;
      default: begin
        got = 1'b1;
        res = '{rx_command, rx_length, rx_data, ({b, rx_crc_low} == ~rx_crc)};
        rx_crc = CRC32_SEED;
      end
    endcase
    rx_pos = got ? POS_START : rx_pos + 4'd1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // result check and prediction, both sampled at the clock edge
  always @(posedge clk) begin : scoreboard
    frame_result_t got_res;
    frame_result_t want_res;
    frame_plan_t   plan;
    bit            has_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_res = '{out_command_byte, out_length_byte, out_data_byte, out_crc_ok};
        if (pending_results.size() == 0) begin
          note_error($sformatf("unexpected result %p", got_res));
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.command !== want_res.command || got_res.length !== want_res.length ||
              got_res.data !== want_res.data || got_res.crc_ok !== want_res.crc_ok)
            note_error($sformatf("result mismatch: exp %02h %02h %02h %0b, got %02h %02h %02h %0b",
                                 want_res.command, want_res.length, want_res.data, want_res.crc_ok,
                                 got_res.command, got_res.length, got_res.data, got_res.crc_ok));
        end
      end
      if (in_valid && in_ready) begin
        frame_rx_step(in_rx_byte, has_res, want_res);
        if (has_res) begin
          if (frames_in_flight.size() != 0) begin
            plan = frames_in_flight.pop_front();
            if (plan.typed) want_res = plan.want;
          end
          pending_results.push_back(want_res);
        end
      end
    end
  end

  // receiver pacing, with the occasional long hold-off
  initial begin : result_sink
    rx_pace_t pace;
    int pace_left;
    int period;
    int cyc;
    pace = PACE_OPEN;
    pace_left = 0;
    period = 2;
    cyc = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_done_cnt) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done_cnt = hold_req_cnt;
      end else begin
        if (pace_left == 0) begin
          pace = rx_pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 200);
          period = $urandom_range(2, 8);
        end
        pace_left--;
        cyc++;
        case (pace)
          PACE_OPEN:     out_ready <= 1'b1;
          PACE_COIN:     out_ready <= 1'($urandom_range(0, 1));
          PACE_PERIODIC: out_ready <= (cyc % period == 0);
          default:       out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // drive n bytes of the frame stream, picking up mid-frame where the last call stopped
  task automatic send_stream(input int n);
    logic [31:0] c;
    logic [7:0]  b;
    repeat (n) begin
      if (tx_pos == 0) begin
        cur_plan = (queued_plans.size() != 0) ? queued_plans.pop_front()
                                              : random_frame(mk_start, mk_end);
        frames_in_flight.push_back(cur_plan);
        plan_mk_start = mk_start;
      end
      if (tx_pos == 4) plan_mk_end = mk_end;
      if (tx_pos == 5) begin
        c = crc32_clock_byte(CRC32_SEED, plan_mk_start);
        c = crc32_clock_byte(c, cur_plan.command);
        c = crc32_clock_byte(c, cur_plan.length);
        c = crc32_clock_byte(c, cur_plan.data);
        c = ~crc32_clock_byte(c, plan_mk_end);
        case (cur_plan.kind)
          CRC_GOOD: plan_crc_wire = c;
          CRC_FLIP: plan_crc_wire = c ^ cur_plan.crc_arg;
          default:  plan_crc_wire = cur_plan.crc_arg;
        endcase
      end
      case (tx_pos)
        0:       b = cur_plan.start_byte;
        1:       b = cur_plan.command;
        2:       b = cur_plan.length;
        3:       b = cur_plan.data;
        4:       b = cur_plan.end_byte;
        default: b = plan_crc_wire[8*(tx_pos-5) +: 8];
      endcase
      send_byte(b);
      tx_pos = (tx_pos == FRAME_BYTES - 1) ? 0 : tx_pos + 1;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [7:0] wdata, output logic [7:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(wdata);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata[7:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_marker(input logic reg_sel, input logic [7:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    logic [7:0] rd;
    addr = (reg_sel == REG_START_MARKER) ? ADDR_START_MARKER : ADDR_END_MARKER;
    cfg_access(1'b1, addr, value, rd);
    if (reg_sel == REG_START_MARKER) mk_start = value;
    else mk_end = value;
    cfg_access(1'b0, addr, 8'h00, rd);
    if (rd !== value)
      note_error($sformatf("marker readback at %0h: expected %02h, got %02h", addr, value, rd));
  endtask

  initial begin : stimulus
    int phase;
    int random_sent;
    int nbytes;
    int r;
    logic [7:0] s_val;
    logic [7:0] e_val;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_byte  <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, reset markers in force
    foreach (directed_frames[i]) begin
      queued_plans.push_back(directed_frames[i]);
      send_stream(FRAME_BYTES);
    end

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // may stop mid-frame: the new markers then apply to whatever is not yet sampled
      wait_drained();
      case (phase)
        0:       begin s_val = 8'h00; e_val = 8'h00; end
        1:       begin s_val = 8'hFF; e_val = 8'hFF; end
        2:       begin s_val = 8'h00; e_val = 8'hFF; end
        3:       begin s_val = 8'hFF; e_val = 8'h00; end
        4:       begin s_val = START_MARKER_RST; e_val = END_MARKER_RST; end
        default: begin s_val = pick_byte(); e_val = pick_byte(); end
      endcase
      r = (phase < 5) ? 0 : $urandom_range(0, 2);
      if (r != 2) set_marker(REG_START_MARKER, s_val);
      if (r != 1) set_marker(REG_END_MARKER, e_val);
      @(posedge clk);

      if (phase == 3) begin
        // receiver stalls while bytes keep coming, so the input backs up
        hold_req_cnt <= hold_req_cnt + 1;
        gapless = 1'b1;
        send_stream(8 * FRAME_BYTES);
        gapless = 1'b0;
        random_sent += 8 * FRAME_BYTES;
      end

      nbytes = FRAME_BYTES * $urandom_range(3, 20);
      if ($urandom_range(0, 9) < 3) nbytes += $urandom_range(1, FRAME_BYTES - 1);
      send_stream(nbytes);
      random_sent += nbytes;
      phase++;
    end
    send_stream((FRAME_BYTES - tx_pos) % FRAME_BYTES);
    wait_drained();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
